/* rtl/assert_macros.svh */
// Assertion macros for the port-level checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// consequent in the cycle after antecedent
`define BB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
// consequent in the same cycle as antecedent
`define BB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/bblur_pkg.sv */
// Types and constants for the 5x5 RGB box blur.
// No dependencies.
package bblur_pkg;
	localparam int SAMPLE_W  = 8;
	localparam int PIXEL_W   = 24;
	localparam int SUM_W     = 13;
	localparam int CNT_W     = 5;
	localparam int SLOTS     = 6;
	localparam int DIV_STEPS = 13;
	localparam int REG_W     = 11;
	localparam logic [REG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [REG_W-1:0] HEIGHT_RESET = 11'd480;
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic clr;
		logic acc;
		logic load;
		logic step;
	} lane_ctl_t;
endpackage

/* rtl/bblur_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bblur_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 6144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/bblur_lane.sv */
// One colour lane: window sum accumulator and restoring divider.
// Depends on bblur_pkg.
module bblur_lane (
	input  logic                                 clk,
	input  bblur_pkg::lane_ctl_t                 ctl,
	input  logic [bblur_pkg::SAMPLE_W-1:0]       sample,
	input  logic [bblur_pkg::CNT_W-1:0]          divisor,
	output logic [bblur_pkg::SAMPLE_W-1:0]       quot
);
	logic [bblur_pkg::SUM_W-1:0] sum_q;
	logic [bblur_pkg::SUM_W-1:0] quo_q;
	logic [bblur_pkg::CNT_W-1:0] rem_q;
	logic [bblur_pkg::CNT_W:0]   trial;
	logic                        fits;

	assign trial = {rem_q, quo_q[bblur_pkg::SUM_W-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign quot  = quo_q[bblur_pkg::SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= sum_q + bblur_pkg::SUM_W'(sample);
		end
		if (ctl.load) begin
			rem_q <= '0;
			quo_q <= sum_q;
		end else if (ctl.step) begin
			rem_q <= fits ? bblur_pkg::CNT_W'(trial - {1'b0, divisor})
				: trial[bblur_pkg::CNT_W-1:0];
			quo_q <= {quo_q[bblur_pkg::SUM_W-2:0], fits};
		end
	end
endmodule

/* rtl/box_blur_5x5_rgb_unit.sv */
// channel | signals                                      | transfer when
// in      | in_valid in_ready operation red/green/blue_in | in_valid & in_ready
// out     | out_valid out_ready red/green/blue_out frame_end | out_valid & out_ready
// cfg     | cfg_we cfg_index cfg_data                     | cfg_we
// One item at a time: IDLE and CHECK only when no output is due; else SCAN reads the
// window through the single line-store read port, then TAIL, LOAD, DIV (divide), DONE.
// The result register lets the next item enter while a result waits.
// arst_n clears control state; line store contents are undefined until written.
// Depends on bblur_pkg, bblur_ram and bblur_lane.
module box_blur_5x5_rgb_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        frame_end,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int AW = $clog2(bblur_pkg::SLOTS * MAX_WIDTH);
	localparam int DSW = $clog2(bblur_pkg::DIV_STEPS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHECK, ST_SCAN, ST_TAIL, ST_LOAD, ST_DIV, ST_DONE
	} state_t;

	state_t state_q;
	logic [bblur_pkg::REG_W-1:0] width_q, height_q;
	logic [CW-1:0] w, in_col_q, out_col_q;
	logic [RW-1:0] h, in_row_q, out_row_q;
	logic [2:0] in_slot_q, out_slot_q;
	logic signed [2:0] dx_q, dy_q;
	logic [bblur_pkg::CNT_W-1:0] cnt_q;
	logic [DSW-1:0] step_q;
	logic rd_valid_s1;
	logic in_xfer, wr_en, due, last, out_load;
	logic [CW-1:0] nx;
	logic [RW-1:0] ny;
	logic signed [CW+1:0] sx;
	logic signed [RW+1:0] sy;
	logic in_win;
	logic [3:0] tslot;
	logic [2:0] yslot;
	logic [AW-1:0] waddr, raddr;
	logic [bblur_pkg::PIXEL_W-1:0] rdata;
	logic [bblur_pkg::SAMPLE_W-1:0] q_r, q_g, q_b;
	bblur_pkg::lane_ctl_t ctl;

	assign w = (width_q == '0) ? CW'(1) : (32'(width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH)
		: CW'(width_q);
	assign h = (height_q == '0) ? RW'(1) : (32'(height_q) > MAX_HEIGHT) ? RW'(MAX_HEIGHT)
		: RW'(height_q);

	assign in_ready = state_q == ST_IDLE && !cfg_we;
	assign in_xfer  = in_valid && in_ready;
	assign wr_en    = in_xfer && operation == bblur_pkg::OP_PIXEL && in_row_q < h;
	assign waddr    = AW'(32'(in_slot_q) * MAX_WIDTH + 32'(in_col_q));

	assign nx  = (out_col_q + CW'(2) > w - CW'(1)) ? w - CW'(1) : out_col_q + CW'(2);
	assign ny  = (out_row_q + RW'(2) > h - RW'(1)) ? h - RW'(1) : out_row_q + RW'(2);
	assign due = (ny < in_row_q) || (ny == in_row_q && nx < in_col_q);

	assign sx = $signed({2'b00, out_col_q}) + (CW+2)'(dx_q);
	assign sy = $signed({2'b00, out_row_q}) + (RW+2)'(dy_q);
	assign in_win = sx >= 0 && sx < $signed({2'b00, w}) && sy >= 0
		&& sy < $signed({2'b00, h});
	assign tslot = 4'(out_slot_q) + 4'(dy_q) + 4'(bblur_pkg::SLOTS);
	assign yslot = (tslot >= 4'(2 * bblur_pkg::SLOTS)) ? 3'(tslot - 4'(2 * bblur_pkg::SLOTS))
		: (tslot >= 4'(bblur_pkg::SLOTS)) ? 3'(tslot - 4'(bblur_pkg::SLOTS)) : tslot[2:0];
	assign raddr = AW'(32'(yslot) * MAX_WIDTH + 32'(sx[CW-1:0]));

	assign last = out_col_q == w - CW'(1) && out_row_q == h - RW'(1);
	assign out_load = state_q == ST_DONE && (!out_valid || out_ready) && !cfg_we;

	assign ctl.clr  = state_q == ST_CHECK;
	assign ctl.acc  = rd_valid_s1;
	assign ctl.load = state_q == ST_LOAD;
	assign ctl.step = state_q == ST_DIV;

	bblur_ram #(.WIDTH(bblur_pkg::PIXEL_W), .DEPTH(bblur_pkg::SLOTS * MAX_WIDTH)) u_line (
		.clk(clk), .we(wr_en), .waddr(waddr), .wdata({red_in, green_in, blue_in}),
		.raddr(raddr), .rdata(rdata)
	);

	bblur_lane u_red (.clk(clk), .ctl(ctl), .sample(rdata[23:16]), .divisor(cnt_q),
		.quot(q_r));
	bblur_lane u_green (.clk(clk), .ctl(ctl), .sample(rdata[15:8]), .divisor(cnt_q),
		.quot(q_g));
	bblur_lane u_blue (.clk(clk), .ctl(ctl), .sample(rdata[7:0]), .divisor(cnt_q),
		.quot(q_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			width_q    <= bblur_pkg::WIDTH_RESET;
			height_q   <= bblur_pkg::HEIGHT_RESET;
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			in_slot_q  <= '0;
			out_slot_q <= '0;
			dx_q       <= '0;
			dy_q       <= '0;
			cnt_q      <= '0;
			step_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			rd_valid_s1 <= state_q == ST_SCAN && in_win;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == bblur_pkg::REG_WIDTH) begin
					width_q <= cfg_data;
				end else begin
					height_q <= cfg_data;
				end
				in_col_q   <= '0;
				in_row_q   <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				in_slot_q  <= '0;
				out_slot_q <= '0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (in_xfer) begin
							if (wr_en) begin
								if (in_col_q + CW'(1) >= w) begin
									in_col_q  <= '0;
									in_row_q  <= in_row_q + RW'(1);
									in_slot_q <= (in_slot_q == 3'(bblur_pkg::SLOTS - 1))
										? 3'd0 : in_slot_q + 3'd1;
								end else begin
									in_col_q <= in_col_q + CW'(1);
								end
							end
							state_q <= ST_CHECK;
						end
					end
					ST_CHECK: begin
						dx_q  <= -3'sd2;
						dy_q  <= -3'sd2;
						cnt_q <= '0;
						state_q <= due ? ST_SCAN : ST_IDLE;
					end
					ST_SCAN: begin
						if (rd_valid_s1) begin
							cnt_q <= cnt_q + bblur_pkg::CNT_W'(1);
						end
						if (dx_q == 3'sd2) begin
							dx_q <= -3'sd2;
							if (dy_q == 3'sd2) begin
								state_q <= ST_TAIL;
							end else begin
								dy_q <= dy_q + 3'sd1;
							end
						end else begin
							dx_q <= dx_q + 3'sd1;
						end
					end
					ST_TAIL: begin
						if (rd_valid_s1) begin
							cnt_q <= cnt_q + bblur_pkg::CNT_W'(1);
						end
						state_q <= ST_LOAD;
					end
					ST_LOAD: begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end
					ST_DIV: begin
						step_q <= step_q + DSW'(1);
						if (step_q == DSW'(bblur_pkg::DIV_STEPS - 1)) begin
							state_q <= ST_DONE;
						end
					end
					ST_DONE: begin
						if (out_load) begin
							if (last) begin
								in_col_q   <= '0;
								in_row_q   <= '0;
								out_col_q  <= '0;
								out_row_q  <= '0;
								in_slot_q  <= '0;
								out_slot_q <= '0;
							end else if (out_col_q + CW'(1) >= w) begin
								out_col_q  <= '0;
								out_row_q  <= out_row_q + RW'(1);
								out_slot_q <= (out_slot_q == 3'(bblur_pkg::SLOTS - 1))
									? 3'd0 : out_slot_q + 3'd1;
							end else begin
								out_col_q <= out_col_q + CW'(1);
							end
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			red_out   <= q_r;
			green_out <= q_g;
			blue_out  <= q_b;
			frame_end <= last;
		end
	end
endmodule

/* rtl/bblur_chk.sv */
// Port-level checker for the box blur unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module bblur_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic frame_end
);
	`BB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(frame_end))
	`BB_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	`BB_ASSERT_SAME(a_result_after_work, clk, arst_n, $rose(out_valid), !$past(in_ready))
endmodule

bind box_blur_5x5_rgb_unit bblur_chk u_bblur_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .frame_end(frame_end)
);

/* tb/sv/box_blur_5x5_rgb_unit_tb.sv */
// Self-checking testbench for the 5x5 RGB box blur unit.
// Drives random frames of small sizes through valid/ready and checks every output pixel.
// Depends on bblur_pkg and box_blur_5x5_rgb_unit.
module box_blur_5x5_rgb_unit_tb;
	localparam int MAXW = 1024;
	localparam int MAXH = 1024;
	localparam int RING = 6;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       fe;
	} blur_px_t;

	typedef struct {
		logic       op;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       chk;
		blur_px_t   res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = bblur_pkg::OP_PIXEL;
	logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] red_out, green_out, blue_out;
	logic frame_end;
	logic cfg_we = 1'b0;
	logic cfg_index = bblur_pkg::REG_WIDTH;
	logic [10:0] cfg_data = '0;

	box_blur_5x5_rgb_unit DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [23:0] rows_mem [RING][MAXW];
	logic [10:0] reg_w, reg_h;
	int unsigned col_in, row_in, col_out, row_out;
	blur_px_t blurred_q[$];
	int errors = 0;
	int cycles = 0;
	int out_wait = 0;
	int frame_w, frame_h;

	function automatic int unsigned eff(logic [10:0] v, int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic model_cfg(logic idx, logic [10:0] v);
		if (idx == bblur_pkg::REG_WIDTH) reg_w = v;
		else reg_h = v;
		col_in = 0; row_in = 0; col_out = 0; row_out = 0;
	endtask

	// returns 1 and the pixel when this transfer releases an output
	function automatic bit blur_step(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			output blur_px_t px);
		int unsigned w, h, got, nx, ny, sr, sg, sb, n;
		int x, y;
		logic [23:0] v;
		w = eff(reg_w, MAXW);
		h = eff(reg_h, MAXH);
		sr = 0; sg = 0; sb = 0; n = 0;
		px = '0;
		if (op == bblur_pkg::OP_PIXEL && row_in < h) begin
			rows_mem[row_in % RING][col_in] = {r, g, b};
			col_in++;
			if (col_in >= w) begin
				col_in = 0;
				row_in++;
			end
		end
		got = row_in * w + col_in;
		nx = (col_out + 2 > w - 1) ? w - 1 : col_out + 2;
		ny = (row_out + 2 > h - 1) ? h - 1 : row_out + 2;
		if (ny * w + nx >= got) return 0;
		for (int dy = -2; dy <= 2; dy++) begin
			y = int'(row_out) + dy;
			if (y < 0 || y >= int'(h)) continue;
			for (int dx = -2; dx <= 2; dx++) begin
				x = int'(col_out) + dx;
				if (x < 0 || x >= int'(w)) continue;
				v = rows_mem[y % RING][x];
				sr += v[23:16]; sg += v[15:8]; sb += v[7:0];
				n++;
			end
		end
		if (n == 0) n = 1;
		px.r = 8'(sr / n); px.g = 8'(sg / n); px.b = 8'(sb / n);
		px.fe = (col_out == w - 1) && (row_out == h - 1);
		if (px.fe) begin
			col_in = 0; row_in = 0; col_out = 0; row_out = 0;
		end else begin
			col_out++;
			if (col_out >= w) begin
				col_out = 0;
				row_out++;
			end
		end
		return 1;
	endfunction

	task automatic idle_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [10:0] v);
		@(negedge clk);
		cfg_we = 1'b1; cfg_index = idx; cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		model_cfg(idx, v);
	endtask

	task automatic wait_drained();
		while (blurred_q.size() != 0) @(negedge clk);
		idle_cycles(60);
	endtask

	// one transfer; typed-in expectation when chk is set
	task automatic send_px(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			bit chk, blur_px_t want);
		blur_px_t p;
		bit hit;
		idle_cycles($urandom_range(0, 12));
		in_valid = 1'b1; operation = op; red_in = r; green_in = g; blue_in = b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		hit = blur_step(op, r, g, b, p);
		if (chk && (!hit || p != want)) begin
			$error("typed expectation differs from prediction: %h vs %h", want, p);
			errors++;
		end
		if (hit) blurred_q.push_back(chk ? want : p);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_frame(int w, int h, int mode);
		logic [7:0] r, g, b;
		for (int i = 0; i < w * h; i++) begin
			case (mode)
			0: begin r = 8'hff; g = 8'hff; b = 8'hff; end
			1: begin r = 8'h00; g = 8'h00; b = 8'h00; end
			default: begin
				r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
			end
			endcase
			send_px(bblur_pkg::OP_PIXEL, r, g, b, 0, '0);
		end
		// drain tail, occasionally with a dropped pixel in place of a tick
		while (!(col_in == 0 && row_in == 0 && col_out == 0 && row_out == 0)) begin
			if ($urandom_range(0, 3) == 0)
				send_px(bblur_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
					0, '0);
			else
				send_px(bblur_pkg::OP_DRAIN, 8'd0, 8'd0, 8'd0, 0, '0);
		end
	endtask

	// output side: random wait per result
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_valid && !out_ready) begin
			if (out_wait == 0) out_ready <= 1'b1;
			else out_wait <= out_wait - 1;
		end else begin
			out_ready <= 1'b0;
			out_wait <= $urandom_range(0, 12);
		end
	end

	always @(posedge clk) begin
		blur_px_t e;
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (blurred_q.size() == 0) begin
				$error("output with nothing expected");
				errors++;
			end else begin
				e = blurred_q.pop_front();
				if (red_out !== e.r) begin
					$error("red_out expected %0d actual %0d", e.r, red_out); errors++;
				end
				if (green_out !== e.g) begin
					$error("green_out expected %0d actual %0d", e.g, green_out); errors++;
				end
				if (blue_out !== e.b) begin
					$error("blue_out expected %0d actual %0d", e.b, blue_out); errors++;
				end
				if (frame_end !== e.fe) begin
					$error("frame_end expected %0d actual %0d", e.fe, frame_end); errors++;
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	stim_row_t table_rows[$];

	initial begin
		stim_row_t s;
		int total;
		reg_w = bblur_pkg::WIDTH_RESET;
		reg_h = bblur_pkg::HEIGHT_RESET;
		col_in = 0; row_in = 0; col_out = 0; row_out = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: a drain tick after reset gives nothing, two 1x1 frames, 1x2 frame
		write_reg(bblur_pkg::REG_WIDTH, 11'd1);
		write_reg(bblur_pkg::REG_HEIGHT, 11'd1);
		table_rows.push_back('{bblur_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, '0});
		table_rows.push_back('{bblur_pkg::OP_PIXEL, 8'hff, 8'h00, 8'h80, 1'b1,
			'{8'hff, 8'h00, 8'h80, 1'b1}});
		table_rows.push_back('{bblur_pkg::OP_PIXEL, 8'h00, 8'hff, 8'h01, 1'b1,
			'{8'h00, 8'hff, 8'h01, 1'b1}});
		table_rows.push_back('{bblur_pkg::OP_DRAIN, 8'hff, 8'hff, 8'hff, 1'b0, '0});
		foreach (table_rows[i]) begin
			s = table_rows[i];
			send_px(s.op, s.r, s.g, s.b, s.chk, s.res);
		end
		wait_drained();
		write_reg(bblur_pkg::REG_HEIGHT, 11'd2);
		send_px(bblur_pkg::OP_PIXEL, 8'd10, 8'd20, 8'd30, 0, '0);
		send_px(bblur_pkg::OP_PIXEL, 8'd11, 8'd21, 8'd31, 0, '0);
		send_px(bblur_pkg::OP_DRAIN, 8'd0, 8'd0, 8'd0, 0, '0);
		wait_drained();
		// out-of-range sizes: zero acts as one
		write_reg(bblur_pkg::REG_WIDTH, 11'd0);
		write_reg(bblur_pkg::REG_HEIGHT, 11'd3);
		send_frame(1, 3, 0);
		wait_drained();
		write_reg(bblur_pkg::REG_WIDTH, 11'd7);
		write_reg(bblur_pkg::REG_HEIGHT, 11'd0);
		send_frame(7, 1, 1);
		wait_drained();
		// register write mid-frame drops the frame
		write_reg(bblur_pkg::REG_WIDTH, 11'd4);
		write_reg(bblur_pkg::REG_HEIGHT, 11'd4);
		for (int i = 0; i < 3; i++)
			send_px(bblur_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 0, '0);
		wait_drained();
		write_reg(bblur_pkg::REG_HEIGHT, 11'd4);

		// random frames
		total = 0;
		while (total < 250) begin
			frame_w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			frame_h = $urandom_range(1, 8);
			wait_drained();
			write_reg(bblur_pkg::REG_WIDTH, 11'(frame_w));
			write_reg(bblur_pkg::REG_HEIGHT, 11'(frame_h));
			send_frame(frame_w, frame_h, 2);
			total += frame_w * frame_h;
		end
		wait_drained();
		// oversize width, then maximum height: start of a widest row, then of a tallest column
		write_reg(bblur_pkg::REG_WIDTH, 11'h7ff);
		write_reg(bblur_pkg::REG_HEIGHT, 11'd1);
		for (int i = 0; i < 40; i++)
			send_px(bblur_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 0, '0);
		wait_drained();
		write_reg(bblur_pkg::REG_WIDTH, 11'd1);
		write_reg(bblur_pkg::REG_HEIGHT, 11'd1024);
		for (int i = 0; i < 8; i++)
			send_px(bblur_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 0, '0);
		wait_drained();
		write_reg(bblur_pkg::REG_HEIGHT, 11'd480);

		if (errors == 0 && blurred_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/bblur_pkg.sv
rtl/bblur_ram.sv
rtl/bblur_lane.sv
rtl/box_blur_5x5_rgb_unit.sv
rtl/bblur_chk.sv
tb/sv/box_blur_5x5_rgb_unit_tb.sv
